>>> hdl/pfez_pkg.sv
// shared types, constants and helpers of the period estimator
package pfez_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int MEM_WORDS = 3 * HISTORY_DEPTH;
  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int TIME_W = 32;
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 32;
  localparam int PERIOD_W = 42;
  localparam int DIVIDEND_W = TIME_W + 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] SHORT_WINDOW = 3;
  localparam logic [COUNT_W-1:0] LONG_WINDOW = 7;

  typedef enum logic [1:0] {KIND_MAX = 2'd0, KIND_MIN = 2'd1, KIND_ZERO = 2'd2} kind_t;
  typedef enum logic [1:0] {WIN_SHORT = 2'd0, WIN_LONG = 2'd1, WIN_ALL = 2'd2} window_t;
  typedef enum logic [1:0] {ST_OK = 2'd0, ST_FEW = 2'd1, ST_BAD_SEL = 2'd2} status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_CALC, S_READ_OLD, S_LOAD, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic    valid;
    kind_t   kind;
    window_t window;
  } sel_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [COUNT_W-1:0]    divisor;
  } div_req_t;

  function automatic sel_t decode_sel(input logic [3:0] sel);
    sel_t r;
    r.valid = 1'b1;
    r.kind = KIND_MAX;
    r.window = WIN_SHORT;
    unique case (sel)
      4'd1: begin r.kind = KIND_MAX;  r.window = WIN_SHORT; end
      4'd2: begin r.kind = KIND_MIN;  r.window = WIN_SHORT; end
      4'd3: begin r.kind = KIND_ZERO; r.window = WIN_SHORT; end
      4'd4: begin r.kind = KIND_MAX;  r.window = WIN_LONG;  end
      4'd5: begin r.kind = KIND_MIN;  r.window = WIN_LONG;  end
      4'd6: begin r.kind = KIND_ZERO; r.window = WIN_LONG;  end
      4'd7: begin r.kind = KIND_MAX;  r.window = WIN_ALL;   end
      4'd8: begin r.kind = KIND_MIN;  r.window = WIN_ALL;   end
      4'd9: begin r.kind = KIND_ZERO; r.window = WIN_ALL;   end
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input kind_t kind,
                                                input logic [PTR_W-1:0] slot);
    return ADDR_W'(kind) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(slot);
  endfunction

endpackage

>>> hdl/pfez_if.sv
// sample and result channel interfaces
interface pfez_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [pfez_pkg::TIME_W-1:0]           sample_time;
  logic signed [pfez_pkg::VALUE_W-1:0]   sample_value;
  logic                                  last_sample;
  modport source (output valid, sample_time, sample_value, last_sample, input ready);
  modport sink (input valid, sample_time, sample_value, last_sample, output ready);
endinterface

interface pfez_out_if;
  logic                             valid;
  logic                             ready;
  logic [pfez_pkg::PERIOD_W-1:0]    period;
  logic [1:0]                       status;
  modport source (output valid, period, status, input ready);
  modport sink (input valid, period, status, output ready);
endinterface

>>> hdl/period_from_extrema_and_zeros_unit.sv
// top level of the period estimator from extrema and zero crossings
// Each sample item is taken in S_IDLE; each event it causes (up to three:
// maximum, minimum, zero crossing) is then written in S_WRITE one at a time,
// since the event histories share one ram write port. The series is closed by
// the item marked last: the result sequencer then reads the newest and the
// older event time from the ram, runs a bit-serial divide and hands the period
// to the output register, during which no sample is taken; too few events or a
// bad selection skip to the output with a zero period. A finished result waits
// in its own register, so the next series may start while it is not yet taken.
module period_from_extrema_and_zeros_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             result_select_we,
  input  logic [3:0]       result_select_wdata,
  pfez_in_if.sink          in_item,
  pfez_out_if.source       out_item
);

  // config register
  logic [3:0] result_select;

  // per-sample state
  pfez_pkg::state_t state, state_next;
  logic signed [pfez_pkg::VALUE_W-1:0] older_value, previous_value;
  logic [pfez_pkg::TIME_W-1:0] previous_time;
  logic [1:0] samples_seen;

  // event bookkeeping per kind
  logic [pfez_pkg::PTR_W-1:0]   ptr [3];
  logic [pfez_pkg::TIME_W-1:0]  first_time [3];
  logic [pfez_pkg::COUNT_W-1:0] count [3];

  // pending writes of the item just taken
  logic [2:0] pend;
  logic [pfez_pkg::TIME_W-1:0] mid_time, cur_time;
  logic last_flag;

  // result sequencer registers
  pfez_pkg::kind_t   kind_r;
  pfez_pkg::window_t win_r;
  logic [pfez_pkg::COUNT_W-1:0] k_r;
  logic [pfez_pkg::TIME_W-1:0]  newest_r;
  logic [pfez_pkg::PERIOD_W-1:0] res_period;
  pfez_pkg::status_t res_status;

  // output register
  logic out_valid;
  logic [pfez_pkg::PERIOD_W-1:0] out_period;
  logic [1:0] out_status;

  logic accept, out_free;
  logic signed [pfez_pkg::VALUE_W-1:0] v;
  logic ev_min, ev_max, ev_zero;
  pfez_pkg::kind_t wr_kind;
  logic [2:0] wr_mask;
  pfez_pkg::sel_t dec;
  logic [pfez_pkg::PTR_W-1:0] wr_slot, newest_slot, old_slot, cur_ptr;
  logic [pfez_pkg::PTR_W-1:0] kslot;
  logic [pfez_pkg::COUNT_W-1:0] d, lim, k_calc;
  logic [pfez_pkg::TIME_W-1:0] diff;
  logic ram_we;
  logic [pfez_pkg::ADDR_W-1:0] waddr, raddr;
  logic [pfez_pkg::TIME_W-1:0] wdata, rdata;
  pfez_pkg::div_req_t div_req;
  logic div_done;
  logic [pfez_pkg::DIVIDEND_W-1:0] quotient;

  assign accept = in_item.valid && in_item.ready;
  assign in_item.ready = (state == pfez_pkg::S_IDLE);
  assign out_free = !out_valid || out_item.ready;
  assign out_item.valid = out_valid;
  assign out_item.period = out_period;
  assign out_item.status = out_status;
  assign v = in_item.sample_value;

  // event tests: strict crossing on the second sample, inclusive afterwards
  always_comb begin
    ev_min = (samples_seen == 2'd2) && (older_value >= previous_value) && (previous_value <= v);
    ev_max = (samples_seen == 2'd2) && (older_value <= previous_value) && (previous_value >= v);
    ev_zero = ((samples_seen == 2'd1) &&
               (((previous_value < 0) && (v > 0)) || ((v < 0) && (previous_value > 0)))) ||
              ((samples_seen == 2'd2) &&
               (((previous_value <= 0) && (v >= 0)) || ((v <= 0) && (previous_value >= 0))));
  end

  // one pending event written per cycle, lowest kind first
  always_comb begin
    wr_kind = pfez_pkg::KIND_ZERO;
    wr_mask = 3'b100;
    priority if (pend[0]) begin
      wr_kind = pfez_pkg::KIND_MAX;
      wr_mask = 3'b001;
    end else if (pend[1]) begin
      wr_kind = pfez_pkg::KIND_MIN;
      wr_mask = 3'b010;
    end else begin
      wr_kind = pfez_pkg::KIND_ZERO;
      wr_mask = 3'b100;
    end
    wr_slot = ptr[wr_kind];
    ram_we = (state == pfez_pkg::S_WRITE);
    waddr = pfez_pkg::addr_of(wr_kind, wr_slot);
    wdata = (wr_kind == pfez_pkg::KIND_ZERO) ? cur_time : mid_time;
  end

  // result window: k spacings back, limited by the events seen
  always_comb begin
    dec = pfez_pkg::decode_sel(result_select);
    d = count[dec.kind] - 1'b1;
    lim = (dec.window == pfez_pkg::WIN_SHORT) ? pfez_pkg::SHORT_WINDOW : pfez_pkg::LONG_WINDOW;
    if (dec.window == pfez_pkg::WIN_ALL) k_calc = d;
    else k_calc = (d < lim) ? d : lim;
    cur_ptr = (state == pfez_pkg::S_CALC) ? ptr[dec.kind] : ptr[kind_r];
    newest_slot = (cur_ptr == '0) ? pfez_pkg::PTR_W'(pfez_pkg::HISTORY_DEPTH - 1)
                                  : cur_ptr - 1'b1;
    kslot = k_r[pfez_pkg::PTR_W-1:0];
    old_slot = (newest_slot >= kslot) ? newest_slot - kslot
               : newest_slot + pfez_pkg::PTR_W'(pfez_pkg::HISTORY_DEPTH) - kslot;
    raddr = (state == pfez_pkg::S_CALC) ? pfez_pkg::addr_of(dec.kind, newest_slot)
                                        : pfez_pkg::addr_of(kind_r, old_slot);
    diff = newest_r - ((win_r == pfez_pkg::WIN_ALL) ? first_time[kind_r] : rdata);
    div_req.start = (state == pfez_pkg::S_LOAD);
    div_req.divisor = k_r;
    // zero-crossing spacings are half periods, so scale by two more
    div_req.dividend = (kind_r == pfez_pkg::KIND_ZERO) ? {diff, 9'd0} : {1'b0, diff, 8'd0};
  end

  pfez_ram #(.DATA_W(pfez_pkg::TIME_W), .WORDS(pfez_pkg::MEM_WORDS)) u_hist (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  pfez_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .done(div_done), .quotient(quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfez_pkg::S_IDLE: begin
        if (accept) begin
          if (ev_min || ev_max || ev_zero) state_next = pfez_pkg::S_WRITE;
          else if (in_item.last_sample) state_next = pfez_pkg::S_CALC;
        end
      end
      pfez_pkg::S_WRITE: begin
        if ((pend & ~wr_mask) == 3'b000)
          state_next = last_flag ? pfez_pkg::S_CALC : pfez_pkg::S_IDLE;
      end
      pfez_pkg::S_CALC: begin
        if (samples_seen < 2'd2 || !dec.valid || count[dec.kind] <= 1)
          state_next = pfez_pkg::S_OUT;
        else state_next = pfez_pkg::S_READ_OLD;
      end
      pfez_pkg::S_READ_OLD: state_next = pfez_pkg::S_LOAD;
      pfez_pkg::S_LOAD: state_next = pfez_pkg::S_DIV;
      pfez_pkg::S_DIV: if (div_done) state_next = pfez_pkg::S_OUT;
      pfez_pkg::S_OUT: if (out_free) state_next = pfez_pkg::S_IDLE;
      default: state_next = pfez_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pfez_pkg::S_IDLE;
    else state <= state_next;
  end

  // config register, kept across series
  always_ff @(posedge clk) begin
    if (rst) result_select <= 4'd1;
    else if (result_select_we) result_select <= result_select_wdata;
  end

  // sample state and event bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      older_value <= '0;
      previous_value <= '0;
      previous_time <= '0;
      samples_seen <= '0;
      pend <= '0;
      last_flag <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ptr[i] <= '0;
        count[i] <= '0;
      end
    end else begin
      if (accept) begin
        pend <= {ev_zero, ev_min, ev_max};
        last_flag <= in_item.last_sample;
        if (samples_seen != 2'd2) samples_seen <= samples_seen + 1'b1;
        older_value <= previous_value;
        previous_value <= v;
        previous_time <= in_item.sample_time;
        if (ev_max && count[pfez_pkg::KIND_MAX] != pfez_pkg::COUNT_MAX)
          count[pfez_pkg::KIND_MAX] <= count[pfez_pkg::KIND_MAX] + 1'b1;
        if (ev_min && count[pfez_pkg::KIND_MIN] != pfez_pkg::COUNT_MAX)
          count[pfez_pkg::KIND_MIN] <= count[pfez_pkg::KIND_MIN] + 1'b1;
        if (ev_zero && count[pfez_pkg::KIND_ZERO] != pfez_pkg::COUNT_MAX)
          count[pfez_pkg::KIND_ZERO] <= count[pfez_pkg::KIND_ZERO] + 1'b1;
      end
      if (state == pfez_pkg::S_WRITE) begin
        pend <= pend & ~wr_mask;
        ptr[wr_kind] <= (wr_slot == pfez_pkg::PTR_W'(pfez_pkg::HISTORY_DEPTH - 1))
                        ? '0 : wr_slot + 1'b1;
      end
      // series closed: clear the sample state, pointers and counts; the config register is kept
      if (state == pfez_pkg::S_OUT && out_free) begin
        older_value <= '0;
        previous_value <= '0;
        previous_time <= '0;
        samples_seen <= '0;
        for (int i = 0; i < 3; i++) begin
          ptr[i] <= '0;
          count[i] <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_time <= previous_time;
      cur_time <= in_item.sample_time;
      if (ev_max && count[pfez_pkg::KIND_MAX] == '0)
        first_time[pfez_pkg::KIND_MAX] <= previous_time;
      if (ev_min && count[pfez_pkg::KIND_MIN] == '0)
        first_time[pfez_pkg::KIND_MIN] <= previous_time;
      if (ev_zero && count[pfez_pkg::KIND_ZERO] == '0)
        first_time[pfez_pkg::KIND_ZERO] <= in_item.sample_time;
    end
    if (state == pfez_pkg::S_CALC) begin
      kind_r <= dec.kind;
      win_r <= dec.window;
      k_r <= k_calc;
      res_period <= '0;
      if (samples_seen < 2'd2) res_status <= pfez_pkg::ST_FEW;
      else if (!dec.valid) res_status <= pfez_pkg::ST_BAD_SEL;
      else if (count[dec.kind] <= 1) res_status <= pfez_pkg::ST_FEW;
      else res_status <= pfez_pkg::ST_OK;
    end
    if (state == pfez_pkg::S_READ_OLD) newest_r <= rdata;
    if (state == pfez_pkg::S_DIV && div_done) res_period <= pfez_pkg::PERIOD_W'(quotient);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_item.ready) out_valid <= 1'b0;
      if (state == pfez_pkg::S_OUT && out_free) out_valid <= 1'b1;
    end
    if (state == pfez_pkg::S_OUT && out_free) begin
      out_period <= res_period;
      out_status <= res_status;
    end
  end

  // a last item always closes the series before another sample is taken
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    accept && in_item.last_sample |=> !in_item.ready)
    else $error("sample taken right after a last item");

  // no event write may be left over when a new sample is taken
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == pfez_pkg::S_IDLE |-> pend == 3'b000)
    else $error("pending event write lost");

  // a failing status carries a zero period
  a_status_period: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != pfez_pkg::ST_OK |-> out_period == '0)
    else $error("nonzero period with failing status");

  // divider only started after both history reads
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> $past(state) == pfez_pkg::S_READ_OLD)
    else $error("divider started out of sequence");

endmodule

>>> hdl/pfez_ram.sv
// generic simple dual-port ram with registered read
module pfez_ram #(
  parameter int DATA_W = 32,
  parameter int WORDS = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);
  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/pfez_div.sv
// restoring divider, one quotient bit per cycle
module pfez_div (
  input  logic                                clk,
  input  logic                                rst,
  input  pfez_pkg::div_req_t                  req,
  output logic                                done,
  output logic [pfez_pkg::DIVIDEND_W-1:0]     quotient
);
  localparam int CNT_W = $clog2(pfez_pkg::DIVIDEND_W + 1);

  logic [pfez_pkg::COUNT_W:0]   rem;
  logic [pfez_pkg::COUNT_W-1:0] divisor;
  logic [CNT_W-1:0]             cnt;
  logic [pfez_pkg::COUNT_W:0]   shifted;
  logic [pfez_pkg::COUNT_W+1:0] trial;

  assign shifted = {rem[pfez_pkg::COUNT_W-1:0], quotient[pfez_pkg::DIVIDEND_W-1]};
  assign trial = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(pfez_pkg::DIVIDEND_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
    if (req.start) begin
      rem <= '0;
      quotient <= req.dividend;
      divisor <= req.divisor;
    end else if (cnt != '0) begin
      if (!trial[pfez_pkg::COUNT_W+1]) begin
        rem <= trial[pfez_pkg::COUNT_W:0];
        quotient <= {quotient[pfez_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quotient <= {quotient[pfez_pkg::DIVIDEND_W-2:0], 1'b0};
      end
    end
  end
endmodule

>>> bench/tb_pfez_if.sv
// bench helpers: the interfaces come from the rtl; this file holds the bench result type
`timescale 1ns / 1ps
package tb_pfez_util;
  typedef struct {
    logic [41:0] period;
    logic [1:0]  status;
  } period_result_t;
endpackage

>>> bench/tb_top.sv
// self-checking bench for the period estimator from extrema and zero crossings
`timescale 1ns / 1ps
module tb_top;

  logic clk;
  logic rst;
  logic sel_we;
  logic [3:0] sel_wdata;

  pfez_in_if in_item ();
  pfez_out_if out_item ();

  period_from_extrema_and_zeros_unit dut (
    .clk(clk), .rst(rst),
    .result_select_we(sel_we), .result_select_wdata(sel_wdata),
    .in_item(in_item.sink), .out_item(out_item.source)
  );

  // predictor state, mirrors the block
  logic [3:0]  sel_reg;
  logic signed [15:0] older_v, prev_v;
  logic [31:0] prev_t;
  int unsigned seen;
  logic [31:0] hist [3][pfez_pkg::HISTORY_DEPTH];
  logic [31:0] first_t [3];
  logic [31:0] ev_cnt [3];

  tb_pfez_util::period_result_t pending_periods[$];
  int mismatches;
  int results_seen;
  longint cycles;
  bit fail_flag;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // global cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_track();
    older_v = 0; prev_v = 0; prev_t = 0; seen = 0;
    for (int k = 0; k < 3; k++) begin
      first_t[k] = 0; ev_cnt[k] = 0;
      for (int j = 0; j < pfez_pkg::HISTORY_DEPTH; j++) hist[k][j] = 0;
    end
  endfunction

  function automatic void log_event(pfez_pkg::kind_t kd, logic [31:0] t);
    for (int j = pfez_pkg::HISTORY_DEPTH - 1; j > 0; j--) hist[kd][j] = hist[kd][j-1];
    hist[kd][0] = t;
    if (ev_cnt[kd] == 0) first_t[kd] = t;
    if (ev_cnt[kd] != pfez_pkg::COUNT_MAX) ev_cnt[kd] = ev_cnt[kd] + 1;
  endfunction

  // series close: mean spacing of the selected event kind
  function automatic tb_pfez_util::period_result_t series_period();
    tb_pfez_util::period_result_t r;
    int unsigned kd, win, d, k;
    logic [31:0] diff;
    logic [63:0] scaled;
    r.period = '0;
    r.status = pfez_pkg::ST_OK;
    if (seen < 2) begin
      r.status = pfez_pkg::ST_FEW;
      return r;
    end
    if (sel_reg < 1 || sel_reg > 9) begin
      r.status = pfez_pkg::ST_BAD_SEL;
      return r;
    end
    kd = (sel_reg - 1) % 3;
    win = (sel_reg - 1) / 3;
    if (ev_cnt[kd] <= 1) begin
      r.status = pfez_pkg::ST_FEW;
      return r;
    end
    d = ev_cnt[kd] - 1;
    if (win == pfez_pkg::WIN_ALL) begin
      k = d;
      diff = hist[kd][0] - first_t[kd];
    end else begin
      k = (win == pfez_pkg::WIN_SHORT) ? 3 : 7;
      if (d < k) k = d;
      diff = hist[kd][0] - hist[kd][k];
    end
    scaled = {32'd0, diff} << ((kd == pfez_pkg::KIND_ZERO) ? 9 : 8);
    r.period = 42'(scaled / 64'(k));
    return r;
  endfunction

  function automatic void predict_sample(logic [31:0] t, logic signed [15:0] v, bit last);
    if (seen == 0) begin
      seen = 1;
    end else if (seen == 1) begin
      if ((prev_v < 0 && v > 0) || (v < 0 && prev_v > 0)) log_event(pfez_pkg::KIND_ZERO, t);
      seen = 2;
    end else begin
      if (older_v >= prev_v && prev_v <= v) log_event(pfez_pkg::KIND_MIN, prev_t);
      if (older_v <= prev_v && prev_v >= v) log_event(pfez_pkg::KIND_MAX, prev_t);
      if ((prev_v <= 0 && v >= 0) || (v <= 0 && prev_v >= 0))
        log_event(pfez_pkg::KIND_ZERO, t);
    end
    older_v = prev_v;
    prev_v = v;
    prev_t = t;
    if (last) begin
      pending_periods.insert(pending_periods.size(), series_period());
      clear_track();
    end
  endfunction

  // result checker with random receiver stalls
  initial begin
    tb_pfez_util::period_result_t exp_r;
    int gap;
    out_item.ready = 0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_item.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_item.ready <= 1;
      do @(posedge clk); while (!out_item.valid);
      results_seen++;
      if (pending_periods.size() == 0) begin
        fail_flag = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result period=%0h status=%0d",
                                       out_item.period, out_item.status);
      end else begin
        exp_r = pending_periods.pop_front();
        if (out_item.period !== exp_r.period || out_item.status !== exp_r.status) begin
          fail_flag = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp period=%0h status=%0d got period=%0h status=%0d",
                     exp_r.period, exp_r.status, out_item.period, out_item.status);
        end
      end
    end
  end

  // valid stays up after an item until the next item or an idle period drops it
  task automatic send_sample(logic [31:0] t, logic signed [15:0] v, bit last, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_item.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_item.valid <= 1;
    in_item.sample_time <= t;
    in_item.sample_value <= v;
    in_item.last_sample <= last;
    do @(posedge clk); while (!in_item.ready);
    predict_sample(t, v, last);
  endtask

  // wait until all results are in, then let the sequencer settle
  task automatic drain();
    int guard;
    guard = 0;
    in_item.valid <= 0;
    while (pending_periods.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic write_select(logic [3:0] s);
    drain();
    sel_we <= 1;
    sel_wdata <= s;
    @(posedge clk);
    sel_we <= 0;
    sel_reg = s;
  endtask

  // one series of a noisy triangle-like wave with random outliers and zeros
  task automatic send_series(int len, int amp, int step, bit wide_time);
    logic [31:0] t;
    int phase, v;
    t = wide_time ? $urandom : $urandom_range(0, 1000);
    phase = $urandom_range(0, 63);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: v = $urandom_range(0, 65535) - 32768;
        1: v = 0;
        default: v = ((phase % 16) < 8 ? (phase % 8) - 4 : 4 - (phase % 8)) * amp
                     + $urandom_range(0, 3);
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      phase += step;
      send_sample(t, 16'(v), i == len - 1);
      t = t + $urandom_range(0, wide_time ? 32'h0fff_ffff : 40);
    end
  endtask

  task automatic test_directed_extremes();
    write_select(1);
    send_sample(32'd5, 16'sd100, 1);                       // single sample
    send_sample(32'd0, -16'sd32768, 0);
    send_sample(32'd1, 16'sd32767, 0);                     // strict crossing
    send_sample(32'd2, -16'sd32768, 0);
    send_sample(32'd3, 16'sd32767, 0);
    send_sample(32'd4, -16'sd1, 0);
    send_sample(32'hffff_ffff, 16'sd0, 1);                 // wrapping time
    write_select(3);
    send_sample(32'd10, 16'sd0, 0);                        // zero second: not strict
    send_sample(32'd11, 16'sd5, 0);
    send_sample(32'd12, 16'sd0, 0);
    send_sample(32'd20, -16'sd5, 0);
    send_sample(32'd40, 16'sd5, 1);
    write_select(0);                                       // invalid selection
    send_sample(32'd1, 16'sd1, 0);
    send_sample(32'd2, 16'sd2, 1);
    write_select(15);
    send_sample(32'd1, 16'sd1, 1);                         // single beats invalid
    send_sample(32'd1, 16'sd3, 0);
    send_sample(32'd2, -16'sd3, 1);
  endtask

  task automatic test_every_select();
    for (int s = 0; s < 16; s++) begin
      write_select(4'(s));
      send_series($urandom_range(8, 30), $urandom_range(1, 8000), $urandom_range(1, 5), 0);
    end
  endtask

  task automatic test_random_series();
    int count;
    count = 0;
    while (count < 580) begin
      int len;
      if ($urandom_range(0, 7) == 0) write_select(4'($urandom_range(0, 15)));
      len = $urandom_range(0, 5) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 40);
      send_series(len, $urandom_range(1, 8000), $urandom_range(1, 6), $urandom_range(0, 2) == 0);
      count += len;
      // occasional hold-off until the block has nothing left to report
      if ($urandom_range(0, 9) == 0) drain();
    end
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    fail_flag = 0;
    sel_reg = 4'd1;
    clear_track();
    rst = 1;
    sel_we = 0;
    sel_wdata = 0;
    in_item.valid = 0;
    in_item.sample_time = 0;
    in_item.sample_value = 0;
    in_item.last_sample = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed_extremes();
    test_every_select();
    test_random_series();
    drain();
    if (!fail_flag && pending_periods.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
